// File: design/jsd_pkg.sv
// Shared types, codes and constants of the JSON string decoder.
`default_nettype none
package jsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned StatW = 2;

  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChU = 8'h75;
  localparam logic [ByteW-1:0] ChB = 8'h62;
  localparam logic [ByteW-1:0] ChT = 8'h74;
  localparam logic [ByteW-1:0] ChN = 8'h6E;
  localparam logic [ByteW-1:0] ChF = 8'h66;
  localparam logic [ByteW-1:0] ChR = 8'h72;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChDel = 8'h7F;

  localparam logic [CpW-1:0] CpMax = 21'h10FFFF;
  localparam logic [CpW-1:0] Lo2 = 21'h000080;
  localparam logic [CpW-1:0] Lo3 = 21'h000800;
  localparam logic [CpW-1:0] Lo4 = 21'h010000;
  localparam logic [CpW-1:0] SurMin = 21'h00D800;
  localparam logic [CpW-1:0] SurMax = 21'h00DFFF;
  localparam logic [15:0] HiMin = 16'hD800;
  localparam logic [15:0] HiMax = 16'hDBFF;
  localparam logic [15:0] LoMin = 16'hDC00;
  localparam logic [15:0] LoMax = 16'hDFFF;
  localparam logic [CpW-1:0] SuppBase = 21'h010000;

  typedef enum logic [StatW-1:0] {
    STAT_CHAR = 2'd0,
    STAT_DONE = 2'd1,
    STAT_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic           valid;
    status_t        status;
    logic [CpW-1:0] code_point;
  } jsd_res_t;

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
    logic [4:0] d;
    d = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) d = {1'b0, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) d = {1'b0, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) d = {1'b0, 4'(b - 8'h37)};
    return d;
  endfunction

endpackage
`default_nettype wire

// File: design/jsd_in_stage.sv
// Input register stage of the JSON string decoder.
`default_nettype none
module jsd_in_stage
  import jsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] in_byte_req,
  input  wire logic             in_end_of_input,
  input  wire logic             take,
  output logic                  s1_valid,
  output logic [ByteW-1:0]      s1_byte,
  output logic                  s1_eoi
);

  logic             valid_r;
  logic [ByteW-1:0] byte_r;
  logic             eoi_r;
  logic             load;

  assign load     = !valid_r || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      byte_r <= in_byte_req;
      eoi_r  <= in_end_of_input;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_eoi   = eoi_r;

endmodule
`default_nettype wire

// File: design/jsd_core.sv
// Scan state machine: UTF-8 decode, escape and surrogate-pair handling.
`default_nettype none
module jsd_core
  import jsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] b,
  input  wire logic             eoi,
  output jsd_res_t              res
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_BODY  = 16'h0002,
    S_CONT1 = 16'h0004,
    S_CONT2 = 16'h0008,
    S_CONT3 = 16'h0010,
    S_ESC   = 16'h0020,
    S_HI0   = 16'h0040,
    S_HI1   = 16'h0080,
    S_HI2   = 16'h0100,
    S_HI3   = 16'h0200,
    S_LBS   = 16'h0400,
    S_LU    = 16'h0800,
    S_LO0   = 16'h1000,
    S_LO1   = 16'h2000,
    S_LO2   = 16'h4000,
    S_LO3   = 16'h8000
  } scan_t;

  scan_t          state_r, state_nxt;
  logic [CpW-1:0] pc_r, pc_nxt;
  logic [1:0]     len_r, len_nxt;
  logic [9:0]     hs_r, hs_nxt;

  logic [CpW-1:0] cont_val;
  logic [CpW-1:0] lo_bound;
  logic [4:0]     dig;
  logic [15:0]    hex_val;
  logic           fail;
  logic           clear;

  always_comb begin
    cont_val = {pc_r[14:0], b[5:0]};
    dig      = hex_digit(b);
    hex_val  = {pc_r[11:0], dig[3:0]};
    case (len_r)
      2'd1:    lo_bound = Lo2;
      2'd2:    lo_bound = Lo3;
      default: lo_bound = Lo4;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    len_nxt        = len_r;
    hs_nxt         = hs_r;
    fail           = 1'b0;
    clear          = 1'b0;
    res.valid      = 1'b0;
    res.status     = STAT_CHAR;
    res.code_point = '0;
    if (eoi) begin
      fail = 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (b != ChQuote) fail = 1'b1;
          else state_nxt = S_BODY;
        end
        S_BODY: begin
          if (b == ChQuote) begin
            clear      = 1'b1;
            res.valid  = 1'b1;
            res.status = STAT_DONE;
          end else if (b == ChBslash) begin
            state_nxt = S_ESC;
          end else if (b < ChSpace || b == ChDel) begin
            fail = 1'b1;
          end else if (!b[7]) begin
            res.valid      = 1'b1;
            res.code_point = {13'd0, b};
          end else if (b < 8'hC0 || b >= 8'hF8) begin
            fail = 1'b1;
          end else if (b < 8'hE0) begin
            pc_nxt    = {16'd0, b[4:0]};
            len_nxt   = 2'd1;
            state_nxt = S_CONT1;
          end else if (b < 8'hF0) begin
            pc_nxt    = {17'd0, b[3:0]};
            len_nxt   = 2'd2;
            state_nxt = S_CONT2;
          end else begin
            pc_nxt    = {18'd0, b[2:0]};
            len_nxt   = 2'd3;
            state_nxt = S_CONT3;
          end
        end
        S_CONT1, S_CONT2, S_CONT3: begin
          if (b[7:6] != 2'b10) begin
            fail = 1'b1;
          end else if (state_r == S_CONT3) begin
            pc_nxt    = cont_val;
            state_nxt = S_CONT2;
          end else if (state_r == S_CONT2) begin
            pc_nxt    = cont_val;
            state_nxt = S_CONT1;
          end else if (cont_val < lo_bound || cont_val > CpMax ||
                       (cont_val >= SurMin && cont_val <= SurMax)) begin
            fail = 1'b1;
          end else begin
            pc_nxt         = '0;
            len_nxt        = 2'd0;
            state_nxt      = S_BODY;
            res.valid      = 1'b1;
            res.code_point = cont_val;
          end
        end
        S_ESC: begin
          state_nxt = S_BODY;
          res.valid = 1'b1;
          case (b)
            ChB:      res.code_point = 21'h08;
            ChT:      res.code_point = 21'h09;
            ChN:      res.code_point = 21'h0A;
            ChF:      res.code_point = 21'h0C;
            ChR:      res.code_point = 21'h0D;
            ChBslash: res.code_point = {13'd0, ChBslash};
            ChSlash:  res.code_point = {13'd0, ChSlash};
            ChQuote:  res.code_point = {13'd0, ChQuote};
            ChU: begin
              res.valid = 1'b0;
              pc_nxt    = '0;
              state_nxt = S_HI0;
            end
            default: begin
              res.valid = 1'b0;
              fail      = 1'b1;
            end
          endcase
        end
        S_HI0, S_HI1, S_HI2, S_LO0, S_LO1, S_LO2: begin
          if (dig[4]) begin
            fail = 1'b1;
          end else begin
            pc_nxt = {5'd0, hex_val};
            case (state_r)
              S_HI0:   state_nxt = S_HI1;
              S_HI1:   state_nxt = S_HI2;
              S_HI2:   state_nxt = S_HI3;
              S_LO0:   state_nxt = S_LO1;
              S_LO1:   state_nxt = S_LO2;
              default: state_nxt = S_LO3;
            endcase
          end
        end
        S_HI3: begin
          if (dig[4] || (hex_val >= LoMin && hex_val <= LoMax)) begin
            fail = 1'b1;
          end else if (hex_val >= HiMin && hex_val <= HiMax) begin
            pc_nxt    = '0;
            hs_nxt    = hex_val[9:0];
            state_nxt = S_LBS;
          end else begin
            pc_nxt         = '0;
            state_nxt      = S_BODY;
            res.valid      = 1'b1;
            res.code_point = {5'd0, hex_val};
          end
        end
        S_LBS: begin
          if (b != ChBslash) fail = 1'b1;
          else state_nxt = S_LU;
        end
        S_LU: begin
          if (b != ChU) begin
            fail = 1'b1;
          end else begin
            pc_nxt    = '0;
            state_nxt = S_LO0;
          end
        end
        S_LO3: begin
          if (dig[4] || hex_val < LoMin || hex_val > LoMax) begin
            fail = 1'b1;
          end else begin
            hs_nxt         = '0;
            pc_nxt         = '0;
            state_nxt      = S_BODY;
            res.valid      = 1'b1;
            res.code_point = SuppBase + {1'b0, hs_r, hex_val[9:0]};
          end
        end
        default: clear = 1'b1;
      endcase
    end
    if (fail) begin
      clear          = 1'b1;
      res.valid      = 1'b1;
      res.status     = STAT_ERR;
      res.code_point = '0;
    end
    if (clear) begin
      state_nxt = S_IDLE;
      pc_nxt    = '0;
      len_nxt   = 2'd0;
      hs_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      len_r   <= 2'd0;
      hs_r    <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      len_r   <= len_nxt;
      hs_r    <= hs_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/jsd_out_stage.sv
// Result register stage of the JSON string decoder.
`default_nettype none
module jsd_out_stage
  import jsd_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire jsd_res_t       res,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [StatW-1:0]    out_status,
  output logic [CpW-1:0]      out_code_point
);

  logic             valid_r;
  status_t          status_r;
  logic [CpW-1:0]   cp_r;

  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      status_r <= res.status;
      cp_r     <= res.code_point;
    end
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_code_point = cp_r;

endmodule
`default_nettype wire

// File: design/json_string_decoder_unit.sv
// JSON string decoder with UTF-8 and escape decoding, top level: one byte per cycle unless stalled.
//
// Takes JSON text one byte per cycle unless stalled, starting at the opening quote, and
// yields at most one result per byte: a decoded code point, a done result on the closing
// quote, or an error, after which the block waits for the next opening quote. Every byte
// passes through an input register, the combinational scan-state logic and a result
// register, so a new byte can be accepted in every cycle while results drain. The input
// stalls only when a byte that yields a result meets a full result register held by out_stall.
`default_nettype none
module json_string_decoder_unit
  import jsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [ByteW-1:0] in_byte_req,
  input  wire logic             in_end_of_input,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [StatW-1:0]      out_status,
  output logic [CpW-1:0]        out_code_point
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_eoi;
  logic             take;
  logic             out_free;
  jsd_res_t         res;

  assign take = s1_valid && (!res.valid || out_free);

  jsd_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_req     (in_byte_req),
    .in_end_of_input (in_end_of_input),
    .take            (take),
    .s1_valid        (s1_valid),
    .s1_byte         (s1_byte),
    .s1_eoi          (s1_eoi)
  );

  jsd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (take),
    .b     (s1_byte),
    .eoi   (s1_eoi),
    .res   (res)
  );

  jsd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (take && res.valid),
    .res            (res),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_code_point (out_code_point)
  );

  a_zero_cp_unless_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_CHAR |-> out_code_point == '0)
    else $error("code point not zero on done or error result");

  a_scalar_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_CHAR |->
      out_code_point <= CpMax && (out_code_point < SurMin || out_code_point > SurMax))
    else $error("decoded code point is not a Unicode scalar value");

  a_known_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_CHAR || out_status == STAT_DONE ||
                  out_status == STAT_ERR)
    else $error("result status code out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && res.valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// File: tb/json_string_decoder_check.sv
`timescale 1ns / 100ps
// Scoreboard for the JSON string decoder: predicts and compares each result.
module json_string_decoder_check
  import jsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ByteW-1:0] in_byte_req,
  input  logic             in_end_of_input,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [StatW-1:0] out_status,
  input  logic [CpW-1:0]   out_code_point,
  output int               mismatches,
  output int               results_due
);

  localparam logic [CpW-1:0] MinTwo = 21'h000080;
  localparam logic [CpW-1:0] MinThree = 21'h000800;
  localparam logic [CpW-1:0] MinFour = 21'h010000;
  localparam logic [CpW-1:0] MaxScalar = 21'h10FFFF;
  localparam logic [CpW-1:0] SurFirst = 21'h00D800;
  localparam logic [CpW-1:0] SurLast = 21'h00DFFF;
  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast = 16'hDBFF;
  localparam logic [15:0] LowFirst = 16'hDC00;
  localparam logic [15:0] LowLast = 16'hDFFF;
  localparam logic [31:0] PairBias = 32'h035FDC00;

  typedef enum logic [7:0] {
    SC_IDLE   = 8'h01,
    SC_BODY   = 8'h02,
    SC_CONT   = 8'h04,
    SC_ESC    = 8'h08,
    SC_HEX_HI = 8'h10,
    SC_LBS    = 8'h20,
    SC_LU     = 8'h40,
    SC_HEX_LO = 8'h80
  } scan_t;

  typedef struct packed {
    status_t        status;
    logic [CpW-1:0] code_point;
  } decoded_t;

  decoded_t decoded_q[$];

  scan_t          scan;
  logic [CpW-1:0] acc;
  logic [1:0]     conts_due;
  logic [1:0]     seq_len;
  logic [1:0]     nibbles;
  logic [15:0]    hi_sur;

  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b0, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic void restart();
    scan = SC_IDLE;
    acc = '0;
    conts_due = '0;
    seq_len = '0;
    nibbles = '0;
    hi_sur = '0;
  endfunction

  function automatic void queue_result(input status_t st, input logic [CpW-1:0] cp);
    decoded_t item;
    item.status = st;
    item.code_point = cp;
    decoded_q.insert(decoded_q.size(), item);
  endfunction

  function automatic void reject();
    restart();
    queue_result(STAT_ERR, '0);
  endfunction

  function automatic void decode_step(input logic [ByteW-1:0] b, input logic eoi);
    logic [4:0]     dv;
    logic [CpW-1:0] floor_cp;
    logic [15:0]    v16;
    logic [31:0]    pair;
    if (eoi) begin
      reject();
      return;
    end
    unique case (scan)
      SC_IDLE: begin
        if (b == ChQuote) scan = SC_BODY;
        else reject();
      end
      SC_BODY: begin
        if (b == ChQuote) begin
          restart();
          queue_result(STAT_DONE, '0);
        end else if (b == ChBslash) begin
          scan = SC_ESC;
        end else if (b < ChSpace || b == ChDel) begin
          reject();
        end else if (b < 8'h80) begin
          queue_result(STAT_CHAR, {13'd0, b});
        end else if (b < 8'hC0 || b >= 8'hF8) begin
          reject();
        end else begin
          if (b < 8'hE0) begin
            acc = {16'd0, b[4:0]};
            seq_len = 2'd1;
          end else if (b < 8'hF0) begin
            acc = {17'd0, b[3:0]};
            seq_len = 2'd2;
          end else begin
            acc = {18'd0, b[2:0]};
            seq_len = 2'd3;
          end
          conts_due = seq_len;
          scan = SC_CONT;
        end
      end
      SC_CONT: begin
        if (b[7:6] != 2'b10) begin
          reject();
        end else begin
          acc = {acc[14:0], b[5:0]};
          conts_due = conts_due - 2'd1;
          if (conts_due == 2'd0) begin
            floor_cp = (seq_len == 2'd1) ? MinTwo : (seq_len == 2'd2) ? MinThree : MinFour;
            if (acc < floor_cp || acc > MaxScalar || (acc >= SurFirst && acc <= SurLast)) begin
              reject();
            end else begin
              queue_result(STAT_CHAR, acc);
              acc = '0;
              seq_len = '0;
              scan = SC_BODY;
            end
          end
        end
      end
      SC_ESC: begin
        scan = SC_BODY;
        case (b)
          ChB: queue_result(STAT_CHAR, 21'h08);
          ChT: queue_result(STAT_CHAR, 21'h09);
          ChN: queue_result(STAT_CHAR, 21'h0A);
          ChF: queue_result(STAT_CHAR, 21'h0C);
          ChR: queue_result(STAT_CHAR, 21'h0D);
          ChBslash, ChSlash, ChQuote: queue_result(STAT_CHAR, {13'd0, b});
          ChU: begin
            acc = '0;
            nibbles = '0;
            scan = SC_HEX_HI;
          end
          default: reject();
        endcase
      end
      SC_HEX_HI, SC_HEX_LO: begin
        dv = hex_value(b);
        if (dv[4]) begin
          reject();
        end else begin
          acc = {5'd0, acc[11:0], dv[3:0]};
          if (nibbles != 2'd3) begin
            nibbles = nibbles + 2'd1;
          end else begin
            v16 = acc[15:0];
            acc = '0;
            nibbles = '0;
            if (scan == SC_HEX_HI) begin
              if (v16 >= LowFirst && v16 <= LowLast) begin
                reject();
              end else if (v16 >= HighFirst && v16 <= HighLast) begin
                hi_sur = v16;
                scan = SC_LBS;
              end else begin
                queue_result(STAT_CHAR, {5'd0, v16});
                scan = SC_BODY;
              end
            end else begin
              if (v16 < LowFirst || v16 > LowLast) begin
                reject();
              end else begin
                pair = ({16'd0, hi_sur} << 10) + {16'd0, v16} - PairBias;
                queue_result(STAT_CHAR, pair[CpW-1:0]);
                hi_sur = '0;
                scan = SC_BODY;
              end
            end
          end
        end
      end
      SC_LBS: begin
        if (b == ChBslash) scan = SC_LU;
        else reject();
      end
      SC_LU: begin
        if (b == ChU) begin
          acc = '0;
          nibbles = '0;
          scan = SC_HEX_LO;
        end else begin
          reject();
        end
      end
      default: restart();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [CpW-1:0] got,
                                 input logic [CpW-1:0] want);
    $display("%0t mismatch: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    decoded_t want;
    if (!rst_n) begin
      restart();
      decoded_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("transaction with none due, status", {19'd0, out_status}, '0);
        end else begin
          want = decoded_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", {19'd0, out_status}, {19'd0, want.status});
          if (out_code_point !== want.code_point)
            report_mismatch("code_point", out_code_point, want.code_point);
        end
      end
      if (in_valid && !in_stall) decode_step(in_byte_req, in_end_of_input);
    end
    results_due <= decoded_q.size();
  end

endmodule

// File: tb/json_string_decoder_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the JSON string decoder: JSON text stimulus, channel idling and verdict.
module json_string_decoder_unit_test;
  import jsd_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 9;
  localparam int RandomItems = 900;
  localparam int LongHoldCycles = 300;
  localparam int QuietLimit = 4000;
  localparam int DrainCycles = 16;

  typedef struct packed {
    logic [ByteW-1:0] octet;
    logic             eoi;
  } text_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [ByteW-1:0] in_byte_req = '0;
  logic             in_end_of_input = 1'b0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic [StatW-1:0] out_status;
  logic [CpW-1:0]   out_code_point;

  int mismatches;
  int results_due;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 1'b0;
  int quiet_cycles = 0;
  int items_sent = 0;
  text_item_t text_q[$];

  always #(HalfPeriod) clk = ~clk;

  json_string_decoder_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_code_point (out_code_point)
  );

  json_string_decoder_check decode_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_req    (in_byte_req),
    .in_end_of_input(in_end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_code_point (out_code_point),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk);
        long_hold = 1'b0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void put_byte(input logic [ByteW-1:0] b);
    text_q.insert(text_q.size(), {b, 1'b0});
  endfunction

  function automatic void put_end();
    logic [ByteW-1:0] junk;
    junk = 8'($urandom);
    text_q.insert(text_q.size(), {junk, 1'b1});
  endfunction

  function automatic logic [CpW-1:0] pick_cp(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(7))
      0: return CpW'(lo);
      1: return CpW'(hi);
      default: return CpW'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] non_hex_byte();
    logic [ByteW-1:0] b;
    b = 8'($urandom);
    while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) b = 8'($urandom);
    return b;
  endfunction

  function automatic void put_utf8(input logic [CpW-1:0] cp);
    if (cp < 21'h80) begin
      put_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      put_byte({3'b110, cp[10:6]});
      put_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      put_byte({4'b1110, cp[15:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end else begin
      put_byte({5'b11110, cp[20:18]});
      put_byte({2'b10, cp[17:12]});
      put_byte({2'b10, cp[11:6]});
      put_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void put_hex16(input logic [15:0] v);
    put_byte(ChBslash);
    put_byte(ChU);
    for (int i = 3; i >= 0; i--) put_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void put_good_elem();
    logic [CpW-1:0] cp;
    case ($urandom_range(9))
      3: put_utf8(pick_cp(21'h80, 21'h7FF));
      4: begin
        cp = pick_cp(21'h800, 21'hFFFF);
        if (cp inside {[21'hD800:21'hDFFF]}) cp = cp ^ 21'h2000;
        put_utf8(cp);
      end
      5: put_utf8(pick_cp(21'h10000, 21'h10FFFF));
      6: begin
        put_byte(ChBslash);
        case ($urandom_range(7))
          0: put_byte(ChB);
          1: put_byte(ChT);
          2: put_byte(ChN);
          3: put_byte(ChF);
          4: put_byte(ChR);
          5: put_byte(ChBslash);
          6: put_byte(ChSlash);
          default: put_byte(ChQuote);
        endcase
      end
      7: begin
        cp = pick_cp(21'h0, 21'hFFFF);
        if (cp inside {[21'hD800:21'hDFFF]}) cp = cp ^ 21'h2000;
        put_hex16(cp[15:0]);
      end
      8: begin
        cp = pick_cp(21'hD800, 21'hDBFF);
        put_hex16(cp[15:0]);
        cp = pick_cp(21'hDC00, 21'hDFFF);
        put_hex16(cp[15:0]);
      end
      default: begin
        cp = pick_cp(21'h20, 21'h7E);
        if (cp == {13'd0, ChQuote} || cp == {13'd0, ChBslash}) cp = cp + 21'd1;
        put_byte(cp[7:0]);
      end
    endcase
  endfunction

  function automatic void put_fault();
    logic [ByteW-1:0] b;
    logic [CpW-1:0]   cp;
    case ($urandom_range(11))
      0: put_byte($urandom_range(3) == 0 ? ChDel : 8'($urandom_range(8'h1F)));
      1: put_byte(8'($urandom_range(8'hBF, 8'h80)));
      2: put_byte(8'($urandom_range(8'hFF, 8'hF8)));
      3: begin
        put_byte(8'($urandom_range(8'hF7, 8'hC0)));
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        put_byte(b);
      end
      4: begin
        case ($urandom_range(2))
          0: put_byte(8'($urandom_range(8'hC1, 8'hC0)));
          1: begin
            put_byte(8'hE0);
            put_byte(8'($urandom_range(8'h9F, 8'h80)));
          end
          default: begin
            put_byte(8'hF0);
            put_byte(8'($urandom_range(8'h8F, 8'h80)));
            put_byte(8'($urandom_range(8'hBF, 8'h80)));
          end
        endcase
        put_byte(8'($urandom_range(8'hBF, 8'h80)));
      end
      5: begin
        put_byte(8'hED);
        put_byte(8'($urandom_range(8'hBF, 8'hA0)));
        put_byte(8'($urandom_range(8'hBF, 8'h80)));
      end
      6: begin
        if ($urandom_range(1)) begin
          put_byte(8'hF4);
          put_byte(8'($urandom_range(8'hBF, 8'h90)));
        end else begin
          put_byte(8'($urandom_range(8'hF7, 8'hF5)));
          put_byte(8'($urandom_range(8'hBF, 8'h80)));
        end
        put_byte(8'($urandom_range(8'hBF, 8'h80)));
        put_byte(8'($urandom_range(8'hBF, 8'h80)));
      end
      7: begin
        put_byte(ChBslash);
        b = 8'($urandom);
        while (b inside {ChB, ChT, ChN, ChF, ChR, ChBslash, ChSlash, ChQuote, ChU})
          b = 8'($urandom);
        put_byte(b);
      end
      8: begin
        put_byte(ChBslash);
        put_byte(ChU);
        repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom)));
        put_byte(non_hex_byte());
      end
      9: begin
        cp = pick_cp(21'hDC00, 21'hDFFF);
        put_hex16(cp[15:0]);
      end
      10: begin
        cp = pick_cp(21'hD800, 21'hDBFF);
        put_hex16(cp[15:0]);
        case ($urandom_range(3))
          0: begin
            b = 8'($urandom);
            if (b == ChBslash) b = ChQuote;
            put_byte(b);
          end
          1: begin
            put_byte(ChBslash);
            b = 8'($urandom);
            if (b == ChU) b = ChBslash;
            put_byte(b);
          end
          2: begin
            cp = CpW'($urandom_range(16'hFFFF));
            if (cp inside {[21'hDC00:21'hDFFF]}) cp = cp ^ 21'h4000;
            put_hex16(cp[15:0]);
          end
          default: begin
            put_byte(ChBslash);
            put_byte(ChU);
            repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom)));
            put_byte(non_hex_byte());
          end
        endcase
      end
      default: begin
        case ($urandom_range(4))
          1: put_byte(8'($urandom_range(8'hF4, 8'hC2)));
          2: put_byte(ChBslash);
          3: begin
            put_byte(ChBslash);
            put_byte(ChU);
            repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom)));
          end
          4: begin
            cp = pick_cp(21'hD800, 21'hDBFF);
            put_hex16(cp[15:0]);
          end
          default: ;
        endcase
        put_end();
      end
    endcase
  endfunction

  function automatic void put_string(input bit broken);
    if ($urandom_range(9) == 0) repeat ($urandom_range(2, 1)) put_byte(8'($urandom));
    if ($urandom_range(19) == 0) put_end();
    put_byte(ChQuote);
    repeat ($urandom_range(6)) put_good_elem();
    if (broken) put_fault();
    else put_byte(ChQuote);
  endfunction

  task automatic send_item(input logic [ByteW-1:0] b, input logic eoi);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_req <= b;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text();
    text_item_t t;
    while (text_q.size() != 0) begin
      t = text_q.pop_front();
      send_item(t.octet, t.eoi);
      items_sent++;
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  initial begin : stimulus
    int target;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_end();
    put_byte(8'h78);
    put_byte(ChQuote);
    put_byte(ChSpace);
    put_byte(8'h7E);
    put_utf8(21'h80);
    put_utf8(21'h10FFFF);
    put_hex16(16'hDBFF);
    put_hex16(16'hDFFF);
    put_byte(ChQuote);
    put_byte(ChQuote);
    put_byte(8'h1F);
    put_byte(ChQuote);
    put_byte(8'hC0);
    put_byte(8'h80);
    send_text();
    wait_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      target = items_sent + RandomItems / 4;
      while (items_sent < target) begin
        put_string($urandom_range(99) < 25);
        send_text();
        if ($urandom_range(15) == 0) wait_results();
      end
      if (phase == 0) begin
        long_hold = 1'b1;
        put_byte(ChQuote);
        repeat (40) put_byte(8'($urandom_range(8'h5B, 8'h23)));
        put_byte(ChQuote);
        send_text();
      end
      wait_results();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/jsd_pkg.sv
design/jsd_in_stage.sv
design/jsd_core.sv
design/jsd_out_stage.sv
design/json_string_decoder_unit.sv
tb/json_string_decoder_check.sv
tb/json_string_decoder_unit_test.sv
